>>> hw/rtl/acn_pkg.sv
// ---------------------------------------------------------------------------
// acn_pkg
// Types and codes shared by the audio codec capability negotiator.
// ---------------------------------------------------------------------------
package acn_pkg;

  localparam int unsigned CFG_DATA_W  = 48;
  localparam int unsigned CFG_INDEX_W = 2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_MEDIA_TYPE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_CODEC_TYPE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_CODEC_INFO = 2'd2;

  // operations
  localparam logic OP_CAPABILITY = 1'b0;
  localparam logic OP_SET        = 1'b1;

  // codec types
  localparam logic [7:0] CODEC_SBC   = 8'd0;
  localparam logic [7:0] CODEC_MPEG1 = 8'd1;
  localparam logic [7:0] CODEC_AAC   = 8'd2;
  localparam logic [7:0] CODEC_ATRAC = 8'd4;

  // status codes
  localparam logic [3:0] ST_OK               = 4'd0;
  localparam logic [3:0] ST_UNSUPPORTED      = 4'd1;
  localparam logic [3:0] ST_CODEC_UNSUP      = 4'd2;
  localparam logic [3:0] ST_INVALID_CODEC    = 4'd3;
  localparam logic [3:0] ST_INV_FREQ         = 4'd4;
  localparam logic [3:0] ST_INV_CHANNEL_MODE = 4'd5;
  localparam logic [3:0] ST_INV_BLOCK_LEN    = 4'd6;
  localparam logic [3:0] ST_INV_SUBBANDS     = 4'd7;
  localparam logic [3:0] ST_INV_ALLOCATION   = 4'd8;
  localparam logic [3:0] ST_INV_MIN_BITPOOL  = 4'd9;
  localparam logic [3:0] ST_INV_MAX_BITPOOL  = 4'd10;

  typedef struct packed {
    logic        opcode;
    logic [3:0]  remote_media_type;
    logic [7:0]  remote_codec_type;
    logic [47:0] remote_codec_info;
  } acn_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [3:0]  chosen_media_type;
    logic [7:0]  chosen_codec_type;
    logic [47:0] chosen_codec_info;
  } acn_result_t;

endpackage

>>> hw/rtl/audio_codec_capability_negotiator_top.sv
// ---------------------------------------------------------------------------
// audio_codec_capability_negotiator_top
// Negotiates an SBC or AAC configuration against the local capability.
// ---------------------------------------------------------------------------
// channel   ports                          transfer when
// request   start, busy, item              start high and busy low
// result    result_valid, result           result_valid high (one cycle)
// config    cfg_we, cfg_index, cfg_data    cfg_we high
//
// three register stages: checks and intersections, selection, result register
// one request per cycle; a request passes through s1_valid, s2_valid and
// result_valid in turn, and the result transfers while result_valid is high
// busy is always low; the receiver cannot hold results off
// rst clears the local capability registers and all stage valid bits
// ---------------------------------------------------------------------------
module audio_codec_capability_negotiator_top import acn_pkg::*; #(
  parameter int unsigned MIN_BITPOOL_LIMIT = 2,
  parameter int unsigned MAX_BITPOOL_LIMIT = 250
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  acn_item_t              item,
  output logic                   result_valid,
  output acn_result_t            result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // local capability
  logic [3:0]  local_media_type;
  logic [7:0]  local_codec_type;
  logic [47:0] local_codec_info;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_media_type <= '0;
      local_codec_type <= '0;
      local_codec_info <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOCAL_MEDIA_TYPE: local_media_type <= cfg_data[3:0];
        CFG_LOCAL_CODEC_TYPE: local_codec_type <= cfg_data[7:0];
        CFG_LOCAL_CODEC_INFO: local_codec_info <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: checks and intersections
  logic [3:0]  a_vstat;
  logic [3:0]  a_val_status;
  logic [47:0] a_l;
  logic [47:0] a_r;
  logic        a_set;
  logic        a_okbr;
  logic        a_okobj;
  logic        a_okch;
  logic        a_okf;

  acn_validate #(
    .MIN_BITPOOL_LIMIT (MIN_BITPOOL_LIMIT),
    .MAX_BITPOOL_LIMIT (MAX_BITPOOL_LIMIT)
  ) u_validate (
    .remote_type (item.remote_codec_type),
    .codec_info  (item.remote_codec_info),
    .status      (a_val_status)
  );

  assign a_l     = local_codec_info;
  assign a_r     = item.remote_codec_info;
  assign a_set   = (item.opcode == OP_SET);
  assign a_vstat = a_set ? a_val_status : ST_OK;

  always_comb begin
    a_okbr = 1'b1;
    if (a_set) begin
      if (!a_l[23]) begin
        a_okbr = !a_r[23];
      end else if (a_r[23]) begin
        a_okbr = ((~a_l[22:0] & a_r[22:0]) == 23'd0);
      end
    end
    if (a_r[22:0] == 23'd0) begin
      a_okbr = 1'b0;
    end
  end

  assign a_okobj = (|(a_l[47:40] & a_r[47:40])) && (!a_set || $onehot(a_r[47:40]));
  assign a_okch  = (|(a_l[27:26] & a_r[27:26])) && (!a_set || $onehot(a_r[27:26]));
  assign a_okf   = (|(a_l[39:28] & a_r[39:28])) && (!a_set || $onehot(a_r[39:28]));

  logic        s1_valid;
  logic        s1_set;
  logic [3:0]  s1_media;
  logic [7:0]  s1_codec;
  logic [47:0] s1_rinfo;
  logic [3:0]  s1_vstat;
  logic        s1_mismatch;
  logic [3:0]  s1_fq;
  logic [3:0]  s1_cm;
  logic [3:0]  s1_bl;
  logic [1:0]  s1_sb;
  logic [1:0]  s1_am;
  logic        s1_bp_fail;
  logic        s1_aac_ok;
  logic [7:0]  s1_obj;
  logic [11:0] s1_freq;
  logic [1:0]  s1_ch;
  logic [22:0] s1_br;
  logic        s1_vbr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_set      <= a_set;
    s1_media    <= item.remote_media_type;
    s1_codec    <= item.remote_codec_type;
    s1_rinfo    <= a_r;
    s1_vstat    <= a_vstat;
    s1_mismatch <= (item.remote_media_type != local_media_type) ||
                   (item.remote_codec_type != local_codec_type);
    s1_fq       <= a_l[47:44] & a_r[47:44];
    s1_cm       <= a_l[43:40] & a_r[43:40];
    s1_bl       <= a_l[39:36] & a_r[39:36];
    s1_sb       <= a_l[35:34] & a_r[35:34];
    s1_am       <= a_l[33:32] & a_r[33:32];
    s1_bp_fail  <= a_set && ((a_r[31:24] < a_l[31:24]) || (a_r[23:16] > a_l[23:16]));
    s1_aac_ok   <= a_okobj && a_okch && a_okf && a_okbr;
    s1_obj      <= a_l[47:40] & a_r[47:40];
    s1_freq     <= a_l[39:28] & a_r[39:28];
    s1_ch       <= a_l[27:26] & a_r[27:26];
    s1_br       <= a_l[22:0] & a_r[22:0];
    s1_vbr      <= a_l[23] & a_r[23];
  end

  // stage 2: selection
  logic [3:0]  b_f;
  logic [3:0]  b_c;
  logic [3:0]  b_b;
  logic [1:0]  b_s;
  logic [1:0]  b_a;
  logic [7:0]  b_mn;
  logic [7:0]  b_mx;
  logic [3:0]  b_sbc_st;
  logic [47:0] b_sbc_info;
  logic [7:0]  b_obj;
  logic [11:0] b_fsel;
  logic [1:0]  b_ch;
  logic [3:0]  b_aac_st;
  logic [47:0] b_aac_info;
  logic [3:0]  b_st;
  logic [47:0] b_info;

  always_comb begin
    priority if (s1_fq[1]) b_f = 4'h2;
    else if (s1_fq[0])     b_f = 4'h1;
    else if (s1_fq[2])     b_f = 4'h4;
    else                   b_f = 4'h8;

    priority if (s1_cm[0]) b_c = 4'h1;
    else if (s1_cm[1])     b_c = 4'h2;
    else if (s1_cm[2])     b_c = 4'h4;
    else                   b_c = 4'h8;

    priority if (s1_bl[0]) b_b = 4'h1;
    else if (s1_bl[1])     b_b = 4'h2;
    else if (s1_bl[2])     b_b = 4'h4;
    else                   b_b = 4'h8;

    priority if (s1_obj[7]) b_obj = 8'h80;
    else if (s1_obj[6])     b_obj = 8'h40;
    else if (s1_obj[5])     b_obj = 8'h20;
    else if (s1_obj[4])     b_obj = 8'h10;
    else                    b_obj = 8'h00;
  end

  assign b_s  = s1_sb[0] ? 2'd1 : 2'd2;
  assign b_a  = s1_am[0] ? 2'd1 : 2'd2;
  assign b_mn = (s1_rinfo[31:24] > local_codec_info[31:24]) ?
                s1_rinfo[31:24] : local_codec_info[31:24];
  assign b_mx = (s1_rinfo[23:16] < local_codec_info[23:16]) ?
                s1_rinfo[23:16] : local_codec_info[23:16];

  assign b_sbc_st = (s1_fq == 4'd0 || s1_cm == 4'd0 || s1_bl == 4'd0 ||
                     s1_sb == 2'd0 || s1_am == 2'd0 || s1_bp_fail) ?
                    ST_UNSUPPORTED : ST_OK;
  assign b_sbc_info = {b_f, b_c, b_b, b_s, b_a, b_mn, b_mx, 16'h0000};

  assign b_fsel     = s1_freq & (~s1_freq + 12'd1);
  assign b_ch       = s1_ch[0] ? 2'd1 : 2'd2;
  assign b_aac_st   = s1_aac_ok ? ST_OK : ST_UNSUPPORTED;
  assign b_aac_info = s1_set ? s1_rinfo :
                      {b_obj, b_fsel, b_ch, 2'b00, s1_vbr, s1_br};

  always_comb begin
    priority if (s1_vstat != ST_OK) begin
      b_st   = s1_vstat;
      b_info = '0;
    end else if (s1_mismatch) begin
      b_st   = ST_UNSUPPORTED;
      b_info = '0;
    end else if (s1_codec == CODEC_SBC) begin
      b_st   = b_sbc_st;
      b_info = b_sbc_info;
    end else if (s1_codec == CODEC_AAC) begin
      b_st   = b_aac_st;
      b_info = b_aac_info;
    end else begin
      b_st   = ST_UNSUPPORTED;
      b_info = '0;
    end
  end

  logic        s2_valid;
  logic [3:0]  s2_st;
  logic [3:0]  s2_media;
  logic [7:0]  s2_codec;
  logic [47:0] s2_info;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_st    <= b_st;
    s2_media <= s1_media;
    s2_codec <= s1_codec;
    s2_info  <= b_info;
  end

  // stage 3: result register
  acn_result_t result_next;

  always_comb begin
    result_next.status = s2_st;
    if (s2_st == ST_OK) begin
      result_next.chosen_media_type = s2_media;
      result_next.chosen_codec_type = s2_codec;
      result_next.chosen_codec_info = s2_info;
    end else begin
      result_next.chosen_media_type = '0;
      result_next.chosen_codec_type = '0;
      result_next.chosen_codec_info = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= s2_valid;
    end
    result <= result_next;
  end

  // checks
  a_result_follows_request: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start, 3))
    else $error("result without request");

  a_request_gives_result: assert property (@(posedge clk) disable iff (rst)
    ($past(start, 3) && !$past(rst, 3) && !$past(rst, 2) && !$past(rst, 1))
      |-> result_valid)
    else $error("request lost");

  a_reject_clears_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != ST_OK) |->
      (result.chosen_media_type == 4'd0 && result.chosen_codec_type == 8'd0 &&
       result.chosen_codec_info == 48'd0))
    else $error("rejected result carries a configuration");

  a_ok_codec_known: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == ST_OK) |->
      (result.chosen_codec_type == CODEC_SBC || result.chosen_codec_type == CODEC_AAC))
    else $error("accepted configuration with unknown codec");

endmodule

>>> hw/rtl/acn_validate.sv
// ---------------------------------------------------------------------------
// acn_validate
// Field checks on a remote configuration in set mode.
// ---------------------------------------------------------------------------
module acn_validate import acn_pkg::*; #(
  parameter int unsigned MIN_BITPOOL_LIMIT = 2,
  parameter int unsigned MAX_BITPOOL_LIMIT = 250
) (
  input  logic [7:0]  remote_type,
  input  logic [47:0] codec_info,
  output logic [3:0]  status
);

  logic [7:0] oct0;
  logic [7:0] oct1;
  logic [7:0] min_bp;
  logic [7:0] max_bp;
  logic [7:0] lim_lo;
  logic [7:0] lim_hi;

  assign oct0   = codec_info[47:40];
  assign oct1   = codec_info[39:32];
  assign min_bp = codec_info[31:24];
  assign max_bp = codec_info[23:16];
  assign lim_lo = 8'(MIN_BITPOOL_LIMIT);
  assign lim_hi = 8'(MAX_BITPOOL_LIMIT);

  always_comb begin
    priority if (remote_type == CODEC_MPEG1 || remote_type == CODEC_ATRAC) begin
      status = ST_CODEC_UNSUP;
    end else if (remote_type != CODEC_SBC && remote_type != CODEC_AAC) begin
      status = ST_INVALID_CODEC;
    end else if (remote_type == CODEC_AAC) begin
      status = ST_OK;
    end else if (!$onehot(oct0[7:4])) begin
      status = ST_INV_FREQ;
    end else if (!$onehot(oct0[3:0])) begin
      status = ST_INV_CHANNEL_MODE;
    end else if (!$onehot(oct1[7:4])) begin
      status = ST_INV_BLOCK_LEN;
    end else if (!$onehot(oct1[3:2])) begin
      status = ST_INV_SUBBANDS;
    end else if (!$onehot(oct1[1:0])) begin
      status = ST_INV_ALLOCATION;
    end else if (min_bp < lim_lo || min_bp > lim_hi) begin
      status = ST_INV_MIN_BITPOOL;
    end else if (max_bp < lim_lo || max_bp > lim_hi) begin
      status = ST_INV_MAX_BITPOOL;
    end else begin
      status = ST_OK;
    end
  end

endmodule

>>> tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the audio codec capability negotiator. A driver
// feeds queued requests with random gaps, or none in burst phases, a
// predictor works out the status and chosen codec octets for each accepted
// request, and the monitor checks every result transfer field by field
// against the oldest prediction. Directed SBC, AAC and unknown codec cases
// come first, then random phases over several local capability settings.
// ---------------------------------------------------------------------------
module tb_top;
  import acn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BITPOOL_FLOOR = 2;
  localparam int unsigned BITPOOL_CEIL  = 250;
  localparam int unsigned PHASES        = 12;
  localparam int unsigned PHASE_ITEMS   = 62;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  acn_item_t              item = '0;
  logic                   result_valid;
  acn_result_t            result;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  acn_item_t   queued_requests[$];
  acn_result_t awaited_results[$];
  int unsigned mismatch_count = 0;
  int unsigned gap_left = 0;
  bit          took = 1'b0;
  bit          burst = 1'b0;

  logic [3:0]  loc_media;
  logic [7:0]  loc_codec;
  logic [47:0] loc_info;

  audio_codec_capability_negotiator_top #(
    .MIN_BITPOOL_LIMIT(BITPOOL_FLOOR),
    .MAX_BITPOOL_LIMIT(BITPOOL_CEIL)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .result_valid(result_valid),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int unsigned bit_count(logic [15:0] v);
    int unsigned n;
    n = 0;
    for (int i = 0; i < 16; i++) n += 32'(v[i]);
    return n;
  endfunction

  function automatic logic [3:0] pick_pref(logic [3:0] m, logic [3:0] a, logic [3:0] b,
                                           logic [3:0] c, logic [3:0] d);
    if ((m & a) != 0) return a;
    if ((m & b) != 0) return b;
    if ((m & c) != 0) return c;
    return d;
  endfunction

  function automatic acn_result_t negotiate(acn_item_t req);
    acn_result_t res;
    logic [47:0] r, l, chosen;
    logic [3:0]  st, fq, cm, bl;
    logic [1:0]  sb, am, lch, rch;
    logic [7:0]  mn, mx, obj;
    logic [11:0] lf, rf, fsel;
    logic [22:0] br;
    logic        ok;
    bit          set;
    r = req.remote_codec_info;
    l = loc_info;
    chosen = '0;
    st = ST_OK;
    set = (req.opcode == OP_SET);
    if (set) begin
      if (req.remote_codec_type == CODEC_MPEG1 || req.remote_codec_type == CODEC_ATRAC)
        st = ST_CODEC_UNSUP;
      else if (req.remote_codec_type != CODEC_SBC && req.remote_codec_type != CODEC_AAC)
        st = ST_INVALID_CODEC;
      else if (req.remote_codec_type == CODEC_SBC) begin
        if (bit_count(16'(r[47:44])) != 1) st = ST_INV_FREQ;
        else if (bit_count(16'(r[43:40])) != 1) st = ST_INV_CHANNEL_MODE;
        else if (bit_count(16'(r[39:36])) != 1) st = ST_INV_BLOCK_LEN;
        else if (bit_count(16'(r[35:34])) != 1) st = ST_INV_SUBBANDS;
        else if (bit_count(16'(r[33:32])) != 1) st = ST_INV_ALLOCATION;
        else if (r[31:24] < BITPOOL_FLOOR || r[31:24] > BITPOOL_CEIL) st = ST_INV_MIN_BITPOOL;
        else if (r[23:16] < BITPOOL_FLOOR || r[23:16] > BITPOOL_CEIL) st = ST_INV_MAX_BITPOOL;
      end
    end
    if (st == ST_OK) begin
      if (req.remote_media_type != loc_media || req.remote_codec_type != loc_codec) begin
        st = ST_UNSUPPORTED;
      end else if (loc_codec == CODEC_SBC) begin
        fq = l[47:44] & r[47:44];
        cm = l[43:40] & r[43:40];
        bl = l[39:36] & r[39:36];
        sb = l[35:34] & r[35:34];
        am = l[33:32] & r[33:32];
        if (fq == 0 || cm == 0 || bl == 0 || sb == 0 || am == 0) begin
          st = ST_UNSUPPORTED;
        end else if (set && (r[31:24] < l[31:24] || r[23:16] > l[23:16])) begin
          st = ST_UNSUPPORTED;
        end else begin
          mn = (r[31:24] > l[31:24]) ? r[31:24] : l[31:24];
          mx = (r[23:16] < l[23:16]) ? r[23:16] : l[23:16];
          chosen = {pick_pref(fq, 4'h2, 4'h1, 4'h4, 4'h8),
                    pick_pref(cm, 4'h1, 4'h2, 4'h4, 4'h8),
                    pick_pref(bl, 4'h1, 4'h2, 4'h4, 4'h8),
                    sb[0] ? 2'd1 : 2'd2, am[0] ? 2'd1 : 2'd2, mn, mx, 16'h0000};
        end
      end else if (loc_codec == CODEC_AAC) begin
        lf = l[39:28];
        rf = r[39:28];
        lch = l[27:26];
        rch = r[27:26];
        ok = (r[22:0] != 0);
        // vbr rules only bind a set request
        if (set && !l[23] && r[23]) ok = 1'b0;
        if (set && l[23] && r[23] && ((~l[22:0] & r[22:0]) != 0)) ok = 1'b0;
        ok = ok && ((l[47:40] & r[47:40]) != 0) && ((lch & rch) != 0) && ((lf & rf) != 0);
        if (set)
          ok = ok && bit_count(16'(r[47:40])) == 1 && bit_count(16'(rch)) == 1 &&
               bit_count(16'(rf)) == 1;
        if (!ok) begin
          st = ST_UNSUPPORTED;
        end else if (set) begin
          chosen = r;
        end else begin
          obj = '0;
          for (int i = 4; i < 8; i++) if (l[40+i] && r[40+i]) obj = 8'h01 << i;
          fsel = '0;
          for (int i = 11; i >= 0; i--) if (lf[i] && rf[i]) fsel = 12'h001 << i;
          br = l[22:0] & r[22:0];
          chosen = {obj, fsel, (lch[0] && rch[0]) ? 2'd1 : 2'd2, 2'b00, l[23] & r[23], br};
        end
      end else begin
        st = ST_UNSUPPORTED;
      end
    end
    res = '0;
    res.status = st;
    if (st == ST_OK) begin
      res.chosen_media_type = req.remote_media_type;
      res.chosen_codec_type = req.remote_codec_type;
      res.chosen_codec_info = chosen;
    end
    return res;
  endfunction

  task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // request transfer, local register mirror and result check
  always @(posedge clk) begin
    acn_result_t want;
    if (rst) begin
      loc_media = '0;
      loc_codec = '0;
      loc_info = '0;
      took = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOCAL_MEDIA_TYPE: loc_media = cfg_data[3:0];
          CFG_LOCAL_CODEC_TYPE: loc_codec = cfg_data[7:0];
          CFG_LOCAL_CODEC_INFO: loc_info = cfg_data[47:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        awaited_results.push_back(negotiate(item));
        void'(queued_requests.pop_front());
        took = 1'b1;
      end
      if (result_valid) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with none pending, expected nothing, actual %h", $time, result);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 48'(want.status), 48'(result.status));
          check_field("media type", 48'(want.chosen_media_type),
                      48'(result.chosen_media_type));
          check_field("codec type", 48'(want.chosen_codec_type),
                      48'(result.chosen_codec_type));
          check_field("codec info", want.chosen_codec_info, result.chosen_codec_info);
        end
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else if (!start || took) begin
      took = 1'b0;
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (queued_requests.size() > 0) begin
        start <= 1'b1;
        item <= queued_requests[0];
        gap_left = burst ? 0 : $urandom_range(4, 0);
      end else begin
        start <= 1'b0;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  task automatic push_req(logic op, logic [3:0] m, logic [7:0] c, logic [47:0] info);
    acn_item_t req;
    req.opcode = op;
    req.remote_media_type = m;
    req.remote_codec_type = c;
    req.remote_codec_info = info;
    queued_requests.push_back(req);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_config(logic [3:0] m, logic [7:0] c, logic [47:0] info);
    write_reg(CFG_LOCAL_MEDIA_TYPE, CFG_DATA_W'(m));
    write_reg(CFG_LOCAL_CODEC_TYPE, CFG_DATA_W'(c));
    write_reg(CFG_LOCAL_CODEC_INFO, info);
    @(posedge clk);
  endtask

  task automatic drain();
    while (queued_requests.size() != 0 || awaited_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // one set bit, usually one the local side also has
  function automatic logic [15:0] one_of(logic [15:0] mask, int unsigned w);
    int unsigned idx[$];
    for (int i = 0; i < w; i++) if (mask[i]) idx.push_back(i);
    if (idx.size() == 0 || $urandom_range(9, 0) == 0) return 16'h0001 << $urandom_range(w - 1, 0);
    return 16'h0001 << idx[$urandom_range(idx.size() - 1, 0)];
  endfunction

  function automatic logic [47:0] rand_local_info(logic [7:0] c);
    logic [47:0] v;
    v = {16'($urandom), 32'($urandom)};
    if (c == CODEC_SBC) begin
      v[47:32] = v[47:32] | 16'($urandom);
      if ($urandom_range(3, 0) != 0) begin
        v[31:24] = 8'($urandom_range(40, BITPOOL_FLOOR));
        v[23:16] = 8'($urandom_range(BITPOOL_CEIL, 60));
      end
    end else if (c == CODEC_AAC) begin
      v[47:24] = v[47:24] | 24'($urandom);
    end
    return v;
  endfunction

  function automatic logic [47:0] rand_sbc_info(logic [47:0] l, bit tidy);
    logic [47:0] v;
    logic [15:0] opts;
    int unsigned lo, hi;
    v = {16'($urandom), 32'($urandom)};
    opts = {4'(one_of(16'(l[47:44]), 4)), 4'(one_of(16'(l[43:40]), 4)),
            4'(one_of(16'(l[39:36]), 4)), 2'(one_of(16'(l[35:34]), 2)),
            2'(one_of(16'(l[33:32]), 2))};
    lo = (l[31:24] < BITPOOL_FLOOR) ? BITPOOL_FLOOR : 32'(l[31:24]);
    hi = (l[23:16] > BITPOOL_CEIL) ? BITPOOL_CEIL : 32'(l[23:16]);
    if (lo > hi) begin
      lo = BITPOOL_FLOOR;
      hi = BITPOOL_CEIL;
    end
    if (tidy) begin
      v[47:32] = opts;
      v[31:24] = 8'($urandom_range(hi, lo));
      v[23:16] = 8'($urandom_range(hi, 32'(v[31:24])));
    end else begin
      v[47:32] = v[47:32] | opts;
    end
    return v;
  endfunction

  function automatic logic [47:0] rand_aac_info(logic [47:0] l, bit tidy);
    logic [47:0] v;
    logic [23:0] head;
    logic        vbr;
    logic [22:0] rate;
    v = {16'($urandom), 32'($urandom)};
    head = {8'(one_of(16'(l[47:40]), 8)), 12'(one_of(16'(l[39:28]), 12)),
            2'(one_of(16'(l[27:26]), 2)), 2'($urandom)};
    vbr = l[23] ? 1'($urandom) : ($urandom_range(9, 0) == 0);
    rate = vbr ? (l[22:0] & 23'($urandom)) : 23'($urandom);
    if (rate == '0 && $urandom_range(9, 0) != 0) rate = l[22:0];
    if (tidy) v = {head, vbr, rate};
    else v[47:24] = v[47:24] | head;
    return v;
  endfunction

  initial begin
    logic [3:0]  cur_media, m;
    logic [7:0]  cur_codec, c;
    logic [47:0] cur_info, info;
    logic        op;
    int unsigned pick;
    bit          tidy;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // local capability still at reset
    push_req(OP_CAPABILITY, 4'd0, CODEC_SBC, 48'hFFFF_FFFF_FFFF);
    push_req(OP_SET, 4'd0, CODEC_MPEG1, 48'h0);
    push_req(OP_SET, 4'd0, CODEC_ATRAC, 48'h0);
    push_req(OP_SET, 4'd15, 8'hFF, 48'hFFFF_FFFF_FFFF);
    push_req(OP_CAPABILITY, 4'd0, CODEC_AAC, 48'hFFFF_FFFF_FFFF);
    drain();

    // sbc, full bitpool range
    load_config(4'd0, CODEC_SBC, 48'hFFFF_02FA_0000);
    push_req(OP_CAPABILITY, 4'd0, CODEC_SBC, 48'hFFFF_FFFF_FFFF);
    push_req(OP_CAPABILITY, 4'd0, CODEC_SBC, 48'h888A_0505_0000);
    push_req(OP_SET, 4'd0, CODEC_SBC, 48'h2119_0A40_0000);
    push_req(OP_SET, 4'd0, CODEC_SBC, 48'h0119_0A40_0000);
    push_req(OP_SET, 4'd0, CODEC_SBC, 48'h2019_0A40_0000);
    push_req(OP_SET, 4'd0, CODEC_SBC, 48'h2139_0A40_0000);
    push_req(OP_SET, 4'd0, CODEC_SBC, 48'h211D_0A40_0000);
    push_req(OP_SET, 4'd0, CODEC_SBC, 48'h2118_0A40_0000);
    push_req(OP_SET, 4'd0, CODEC_SBC, 48'h2119_0140_0000);
    push_req(OP_SET, 4'd0, CODEC_SBC, 48'h2119_FB40_0000);
    push_req(OP_SET, 4'd0, CODEC_SBC, 48'h2119_0AFF_0000);
    push_req(OP_SET, 4'd1, CODEC_SBC, 48'h2119_0A40_0000);
    drain();

    // sbc, narrow bitpool range
    load_config(4'd0, CODEC_SBC, 48'hFFFF_1464_0000);
    push_req(OP_SET, 4'd0, CODEC_SBC, 48'h2119_0A40_0000);
    push_req(OP_SET, 4'd0, CODEC_SBC, 48'h2119_20C8_0000);
    push_req(OP_SET, 4'd0, CODEC_SBC, 48'h2119_2050_ABCD);
    drain();

    // aac with vbr and a limited bitrate
    load_config(4'd0, CODEC_AAC, {8'hFF, 12'hFFF, 2'b11, 2'b00, 1'b1, 23'h00FFFF});
    push_req(OP_CAPABILITY, 4'd0, CODEC_AAC, {8'h0F, 12'hFFF, 2'b11, 2'b00, 1'b1, 23'h7FFFFF});
    push_req(OP_CAPABILITY, 4'd0, CODEC_AAC, {8'h80, 12'h000, 2'b01, 2'b00, 1'b0, 23'h001000});
    push_req(OP_SET, 4'd0, CODEC_AAC, {8'h80, 12'h800, 2'b01, 2'b00, 1'b1, 23'h000000});
    push_req(OP_SET, 4'd0, CODEC_AAC, {8'h80, 12'h800, 2'b01, 2'b00, 1'b1, 23'h010000});
    push_req(OP_SET, 4'd0, CODEC_AAC, {8'h80, 12'h800, 2'b01, 2'b00, 1'b0, 23'h7FFFFF});
    push_req(OP_SET, 4'd0, CODEC_AAC, {8'hC0, 12'h800, 2'b01, 2'b00, 1'b0, 23'h7FFFFF});
    drain();

    // unknown local codec, all ones
    load_config(4'd15, 8'hFF, 48'hFFFF_FFFF_FFFF);
    push_req(OP_CAPABILITY, 4'd15, 8'hFF, 48'hFFFF_FFFF_FFFF);
    push_req(OP_SET, 4'd15, 8'hFF, 48'hFFFF_FFFF_FFFF);
    drain();

    // aac without vbr
    load_config(4'd3, CODEC_AAC, {8'h80, 12'h001, 2'b01, 2'b00, 1'b0, 23'h000001});
    push_req(OP_SET, 4'd3, CODEC_AAC, {8'h80, 12'h001, 2'b01, 2'b00, 1'b1, 23'h000001});
    push_req(OP_CAPABILITY, 4'd3, CODEC_AAC, {8'hFF, 12'hFFF, 2'b11, 2'b11, 1'b1, 23'h7FFFFF});
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          cur_media = 4'd0;
          cur_codec = CODEC_SBC;
          cur_info = '1;
        end
        1: begin
          cur_media = 4'd15;
          cur_codec = CODEC_AAC;
          cur_info = '1;
        end
        2: begin
          cur_media = 4'd0;
          cur_codec = CODEC_AAC;
          cur_info = '0;
        end
        default: begin
          cur_media = $urandom_range(1, 0) ? 4'd0 : 4'($urandom);
          pick = $urandom_range(9, 0);
          cur_codec = (pick < 4) ? CODEC_SBC : (pick < 8) ? CODEC_AAC
                    : (pick == 8) ? CODEC_MPEG1 : 8'($urandom);
          cur_info = rand_local_info(cur_codec);
        end
      endcase
      burst = (p % 3 == 2);
      load_config(cur_media, cur_codec, cur_info);
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(99, 0);
        op = 1'($urandom);
        if (pick < 75) begin
          // built from the local capability, mostly well-formed against it
          m = ($urandom_range(19, 0) == 0) ? 4'($urandom) : cur_media;
          c = cur_codec;
          tidy = op ? ($urandom_range(9, 0) != 0) : 1'($urandom);
          if (c == CODEC_AAC) info = rand_aac_info(cur_info, tidy);
          else info = rand_sbc_info(cur_info, tidy);
        end else if (pick < 90) begin
          m = $urandom_range(1, 0) ? cur_media : 4'($urandom);
          case ($urandom_range(5, 0))
            0: c = CODEC_SBC;
            1: c = CODEC_MPEG1;
            2: c = CODEC_AAC;
            3: c = CODEC_ATRAC;
            4: c = 8'hFF;
            default: c = 8'($urandom);
          endcase
          info = {16'($urandom), 32'($urandom)};
        end else begin
          m = 4'($urandom);
          c = 8'($urandom);
          info = {16'($urandom), 32'($urandom)};
        end
        push_req(op, m, c, info);
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
